// ----- rtl/iais_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iais_pkg
// Shared types and constants of the indexed word store with insert and shift.
// ----------------------------------------------------------------------------
package iais_pkg;

	localparam int DEPTH   = 16;
	localparam int WORD_W  = 32;
	localparam int ACT_W   = 2;
	// The fill count and the index both reach DEPTH itself.
	localparam int FILL_W  = $clog2(DEPTH + 1);
	localparam int STAT_W  = 2;
	localparam int IDX_W   = $clog2(DEPTH);

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_READ   = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_NOP   = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic              exec;
		op_t               op;
		status_t           status;
		logic [FILL_W-1:0] pos;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [FILL_W-1:0] count;
		logic              full;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/iais_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iais_req_if / iais_rsp_if
// Valid/ready channels for requests and responses of the word store.
// ----------------------------------------------------------------------------
interface iais_req_if;
	logic                                valid;
	logic                                ready;
	logic [iais_pkg::ACT_W-1:0]          action;
	logic [iais_pkg::FILL_W-1:0]         index;
	logic signed [iais_pkg::WORD_W-1:0]  value;

	modport source (output valid, output action, output index, output value, input ready);
	modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface iais_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [iais_pkg::WORD_W-1:0]  read_word;
	logic [iais_pkg::STAT_W-1:0]         status;
	logic [iais_pkg::FILL_W-1:0]         fill_count;

	modport source (output valid, output read_word, output status, output fill_count,
		input ready);
	modport sink   (input valid, input read_word, input status, input fill_count,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/indexed_array_insert_shift.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_insert_shift
// Store of up to 16 signed words with append, read, insert and clear.
// ----------------------------------------------------------------------------
// Each request transfer yields exactly one response transfer, which is offered
// in the cycle after it is accepted. A new request is taken every cycle as long
// as the response side keeps up, since the response register is refilled in the
// cycle it is drained; an insert shifts all words of the register chain at once,
// so no request holds up the next. The store powers up empty; words past the
// fill count are never returned.
module indexed_array_insert_shift (
	input  wire logic clk,
	input  wire logic arst_n,
	iais_req_if.sink  req,
	iais_rsp_if.source rsp
);

	iais_pkg::cmd_t     cmd;
	iais_pkg::dp_stat_t stat;

	iais_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_action (req.action),
		.req_index  (req.index),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	iais_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.wr_value   (req.value),
		.stat       (stat),
		.read_word  (rsp.read_word),
		.status     (rsp.status),
		.fill_count (rsp.fill_count)
	);

endmodule

`default_nettype wire

// ----- rtl/iais_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iais_ctrl
// Handshake state machine and request decoder: checks ranges against the
// fill count and issues one command to the datapath per accepted transfer.
// ----------------------------------------------------------------------------
module iais_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [iais_pkg::ACT_W-1:0]    req_action,
	input  wire logic [iais_pkg::FILL_W-1:0]   req_index,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	input  wire iais_pkg::dp_stat_t            stat,
	output iais_pkg::cmd_t                     cmd
);

	typedef enum logic [1:0] {
		S_EMPTY = 2'b01,
		S_HELD  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// The response register can be refilled in the cycle it is drained.
	assign rsp_valid = (state_q == S_HELD);
	assign req_ready = (state_q == S_EMPTY) || rsp_ready;
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		if (accept) begin
			state_d = S_HELD;
		end else if (rsp_ready) begin
			state_d = S_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.exec   = accept;
		cmd.op     = iais_pkg::OP_NOP;
		cmd.status = iais_pkg::ST_OK;
		cmd.pos    = req_index;
		case (iais_pkg::action_t'(req_action))
			iais_pkg::ACT_APPEND: begin
				// An append is an insert at the current count, with nothing to shift.
				cmd.pos = stat.count;
				if (stat.full) begin
					cmd.status = iais_pkg::ST_FULL;
				end else begin
					cmd.op = iais_pkg::OP_WRITE;
				end
			end
			iais_pkg::ACT_READ: begin
				if (req_index < stat.count) begin
					cmd.op = iais_pkg::OP_READ;
				end else begin
					cmd.status = iais_pkg::ST_RANGE;
				end
			end
			iais_pkg::ACT_INSERT: begin
				if (req_index > stat.count) begin
					cmd.status = iais_pkg::ST_RANGE;
				end else if (stat.full) begin
					cmd.status = iais_pkg::ST_FULL;
				end else begin
					cmd.op = iais_pkg::OP_WRITE;
				end
			end
			iais_pkg::ACT_CLEAR: begin
				cmd.op = iais_pkg::OP_CLEAR;
			end
			default: begin
				cmd.op = iais_pkg::OP_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/iais_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iais_dpath
// Word register chain with parallel shift, fill count and response register.
// ----------------------------------------------------------------------------
module iais_dpath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire iais_pkg::cmd_t                      cmd,
	input  wire logic signed [iais_pkg::WORD_W-1:0]  wr_value,
	output iais_pkg::dp_stat_t                       stat,
	output logic signed [iais_pkg::WORD_W-1:0]       read_word,
	output logic [iais_pkg::STAT_W-1:0]              status,
	output logic [iais_pkg::FILL_W-1:0]              fill_count
);

	logic signed [iais_pkg::WORD_W-1:0] words_q [iais_pkg::DEPTH];
	logic [iais_pkg::FILL_W-1:0]        count_q;
	logic [iais_pkg::FILL_W-1:0]        count_d;
	logic signed [iais_pkg::WORD_W-1:0] rd_word_d;
	logic signed [iais_pkg::WORD_W-1:0] read_word_q;
	logic [iais_pkg::STAT_W-1:0]        status_q;
	logic [iais_pkg::FILL_W-1:0]        fill_count_q;

	assign stat.count = count_q;
	assign stat.full  = (count_q == iais_pkg::FILL_W'(iais_pkg::DEPTH));

	always_comb begin
		count_d   = count_q;
		rd_word_d = '0;
		case (cmd.op)
			iais_pkg::OP_WRITE: count_d = count_q + 1'b1;
			iais_pkg::OP_READ:  rd_word_d = words_q[cmd.pos[iais_pkg::IDX_W-1:0]];
			iais_pkg::OP_CLEAR: count_d = '0;
			default:            count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// Every word above the insert position, up to the count, takes its lower
	// neighbour in the same cycle; the new value lands at the position.
	always_ff @(posedge clk) begin
		if (cmd.exec && cmd.op == iais_pkg::OP_WRITE) begin
			if (cmd.pos == '0) begin
				words_q[0] <= wr_value;
			end
			for (int i = 1; i < iais_pkg::DEPTH; i++) begin
				if (iais_pkg::FILL_W'(i) == cmd.pos) begin
					words_q[i] <= wr_value;
				end else if (iais_pkg::FILL_W'(i) > cmd.pos &&
						iais_pkg::FILL_W'(i) <= count_q) begin
					words_q[i] <= words_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_word_q  <= rd_word_d;
			status_q     <= cmd.status;
			fill_count_q <= count_d;
		end
	end

	assign read_word  = read_word_q;
	assign status     = status_q;
	assign fill_count = fill_count_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the indexed word store against a behavioural copy of its contents.
// Every accepted request is applied to the copy, which queues the response it
// predicts; each response transfer is then compared field by field. A short
// directed sequence covers the corner cases, then random traffic follows.
// ----------------------------------------------------------------------------
module testbench;
	import iais_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int N_RANDOM    = 800;
	localparam int TAIL_CYCLES = 8;

	typedef struct {
		logic signed [WORD_W-1:0] read_word;
		status_t                  status;
		logic [FILL_W-1:0]        fill_count;
	} store_rsp_t;

	class store_scoreboard;
		logic signed [WORD_W-1:0] words [DEPTH];
		int unsigned              count;
		store_rsp_t               expected_q [$];
		int                       errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		// Applies one accepted request to the copy and queues its response.
		function void note_request(action_t act, logic [FILL_W-1:0] idx,
				logic signed [WORD_W-1:0] val);
			store_rsp_t r;
			int unsigned i;
			r.read_word = '0;
			r.status    = ST_OK;
			case (act)
				ACT_APPEND: begin
					if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						words[count] = val;
						count++;
					end
				end
				ACT_READ: begin
					if (idx < count) r.read_word = words[idx];
					else r.status = ST_RANGE;
				end
				ACT_INSERT: begin
					// The range check takes precedence over the full check.
					if (idx > count) begin
						r.status = ST_RANGE;
					end else if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (i = count; i > idx; i--) words[i] = words[i-1];
						words[idx] = val;
						count++;
					end
				end
				default: begin
					count = 0;
				end
			endcase
			r.fill_count = FILL_W'(count);
			expected_q.push_back(r);
		endfunction

		function void check_response(logic signed [WORD_W-1:0] rd, logic [STAT_W-1:0] st,
				logic [FILL_W-1:0] fc);
			store_rsp_t e;
			if (expected_q.size() == 0) begin
				$error("response with nothing expected: read_word %0d status %0d fill_count %0d",
					rd, st, fc);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (rd !== e.read_word) begin
				$error("read_word: expected %0d, actual %0d", e.read_word, rd);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
			if (fc !== e.fill_count) begin
				$error("fill_count: expected %0d, actual %0d", e.fill_count, fc);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int fill();
			return int'(count);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic quiet;
	int   stall_cycles;

	store_scoreboard sb = new();

	iais_req_if req ();
	iais_rsp_if rsp ();

	indexed_array_insert_shift dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The response side stalls at random unless a quiet stretch is running.
	always @(negedge clk) begin
		rsp.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
	end

	// The request is noted before the response is checked, so that the order
	// holds whatever the latency of the block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request(action_t'(req.action), req.index, req.value);
			if (rsp.valid && rsp.ready)
				sb.check_response(rsp.read_word, rsp.status, rsp.fill_count);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_request(input action_t act, input logic [FILL_W-1:0] idx,
			input logic signed [WORD_W-1:0] val);
		while (!quiet && $urandom_range(99) < 8) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid  <= 1'b1;
		req.action <= act;
		req.index  <= idx;
		req.value  <= val;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		req.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	function automatic logic signed [WORD_W-1:0] random_word();
		case ($urandom_range(9))
			0:       return 32'sh7FFFFFFF;
			1:       return 32'sh80000000;
			2:       return '0;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n;
		int cnt;
		int pick;
		req.valid    = 1'b0;
		req.action   = '0;
		req.index    = '0;
		req.value    = '0;
		rsp.ready    = 1'b0;
		quiet        = 1'b0;
		stall_cycles = 0;
		arst_n       = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed corner cases on an empty, partly filled and full store.
		send_request(ACT_READ, 5'd0, 32'sd1);
		send_request(ACT_INSERT, 5'd1, 32'sd5);
		send_request(ACT_INSERT, 5'd0, -32'sd1);
		send_request(ACT_APPEND, 5'd0, 32'sh7FFFFFFF);
		send_request(ACT_APPEND, 5'd31, 32'sh80000000);
		send_request(ACT_INSERT, 5'd1, 32'sh12345678);
		send_request(ACT_INSERT, 5'd4, 32'sh0F0F0F0F);
		send_request(ACT_READ, 5'd0, '0);
		send_request(ACT_READ, 5'd4, '0);
		send_request(ACT_READ, 5'd5, '0);
		for (n = 0; n < 11; n++) send_request(ACT_APPEND, 5'd0, $urandom);
		send_request(ACT_APPEND, 5'd0, 32'sd7);
		send_request(ACT_INSERT, 5'd16, 32'sd7);
		send_request(ACT_INSERT, 5'd17, 32'sd7);
		send_request(ACT_READ, 5'd15, '0);
		send_request(ACT_READ, 5'd16, '0);
		send_request(ACT_READ, 5'd31, '0);
		send_request(ACT_CLEAR, 5'd31, 32'shFFFFFFFF);
		send_request(ACT_READ, 5'd0, '0);

		// Mostly well-formed traffic that grows the store towards full, with
		// occasional clears and fully random requests mixed in.
		for (n = 0; n < N_RANDOM; n++) begin
			if (n == 200 || n == 600) hold_until_drained();
			quiet = (n >= 300 && n < 450);
			cnt  = sb.fill();
			pick = $urandom_range(99);
			if (pick < 4)
				send_request(ACT_CLEAR, FILL_W'($urandom_range(31)), random_word());
			else if (pick < 34)
				send_request(ACT_APPEND, FILL_W'($urandom_range(31)), random_word());
			else if (pick < 60)
				send_request(ACT_INSERT, FILL_W'($urandom_range(cnt)), random_word());
			else if (pick < 85)
				send_request(ACT_READ, FILL_W'(cnt == 0 ? 0 : $urandom_range(cnt - 1)),
					random_word());
			else
				send_request(action_t'($urandom_range(3)), FILL_W'($urandom_range(31)),
					random_word());
		end
		quiet = 1'b0;

		req.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
